// ===== rtl/core/srdf_pkg.sv =====
package srdf_pkg;

	typedef enum logic [2:0] {
		RADIX_BIN = 3'd0,
		RADIX_OCT = 3'd1,
		RADIX_DEC = 3'd2,
		RADIX_HEX = 3'd3,
		RADIX_BCD = 3'd4
	} radix_t;

	localparam logic [6:0] CH_MINUS = 7'h2D;
	localparam logic [6:0] CH_ZERO  = 7'h30;
	localparam logic [6:0] CH_ONE   = 7'h31;
	localparam logic [6:0] CH_ALPHA = 7'h37;

	function automatic logic [6:0] glyph(input logic [3:0] d);
		logic [6:0] g;
		if (d < 4'd10) begin
			g = CH_ZERO + {3'b000, d};
		end else begin
			g = CH_ALPHA + {3'b000, d};
		end
		return g;
	endfunction

endpackage

// ===== rtl/core/srdf_dabble.sv =====
module srdf_dabble #(
	parameter int NDEC = 10
) (
	input  logic [4*NDEC-1:0] bcd,
	input  logic              shift_in,
	output logic [4*NDEC-1:0] bcd_next
);

	logic [4*NDEC-1:0] adj;

	// Each decimal digit of five or more is corrected by three before the shift.
	always_comb begin
		for (int i = 0; i < NDEC; i++) begin
			if (bcd[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd[4*i +: 4];
			end
		end
	end

	assign bcd_next = {adj[4*NDEC-2:0], shift_in};

endmodule

// ===== rtl/core/srdf_char_sel.sv =====
module srdf_char_sel #(
	parameter int VALUE_WIDTH = 32,
	parameter int NDEC        = 10
) (
	input  srdf_pkg::radix_t                   mode,
	input  logic [$clog2(VALUE_WIDTH)-1:0]     idx,
	input  logic [1:0]                         bit_sel,
	input  logic [VALUE_WIDTH-1:0]             mag,
	input  logic [4*NDEC-1:0]                  bcd,
	output logic [3:0]                         digit,
	output logic [6:0]                         character
);

	import srdf_pkg::*;

	localparam int NOCT = (VALUE_WIDTH + 2) / 3;
	localparam int NHEX = (VALUE_WIDTH + 3) / 4;
	localparam int OW   = 3 * NOCT;
	localparam int HW   = 4 * NHEX;

	logic [OW-1:0] mag_o;
	logic [HW-1:0] mag_h;

	assign mag_o = OW'(mag);
	assign mag_h = HW'(mag);

	always_comb begin
		case (mode)
			RADIX_BIN: begin
				digit = {3'b000, mag[idx]};
			end
			RADIX_OCT: begin
				digit = {1'b0, mag_o[3*idx +: 3]};
			end
			RADIX_HEX: begin
				digit = mag_h[4*idx +: 4];
			end
			RADIX_DEC, RADIX_BCD: begin
				digit = bcd[4*idx +: 4];
			end
			default: begin
				digit = 4'd0;
			end
		endcase
	end

	always_comb begin
		if (mode == RADIX_BCD) begin
			character = digit[bit_sel] ? CH_ONE : CH_ZERO;
		end else begin
			character = glyph(digit);
		end
	end

endmodule

// ===== rtl/core/signed_radix_digit_formatter.sv =====
// An item with a decimal or BCD command first passes through the shift-add-3
// converter; binary, octal and hex items skip that step.
// Leading zero digits are then skipped, and one character leaves per cycle unless the output stalls.
// The block handles one item at a time.
// An undefined command is accepted and gives no character.
// arst_n clears the sequencer and the output valid; data registers are not reset.
module signed_radix_digit_formatter #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          src_valid,
	output logic                          src_ready,
	input  logic signed [VALUE_WIDTH-1:0] value,
	input  logic [2:0]                    command,
	output logic                          dst_valid,
	input  logic                          dst_ready,
	output logic [6:0]                    character,
	output logic                          last
);

	import srdf_pkg::*;

	localparam int IW   = $clog2(VALUE_WIDTH);
	localparam int NDEC = (VALUE_WIDTH * 1233) / 4096 + 1;
	localparam int NOCT = (VALUE_WIDTH + 2) / 3;
	localparam int NHEX = (VALUE_WIDTH + 3) / 4;

	localparam logic [IW-1:0] TOP_BIN = IW'(VALUE_WIDTH - 1);
	localparam logic [IW-1:0] TOP_OCT = IW'(NOCT - 1);
	localparam logic [IW-1:0] TOP_HEX = IW'(NHEX - 1);
	localparam logic [IW-1:0] TOP_DEC = IW'(NDEC - 1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CONV = 5'b00010,
		ST_SIGN = 5'b00100,
		ST_SCAN = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	state_t                   state_q, state_d;
	radix_t                   mode_q;
	logic                     neg_q;
	logic [IW-1:0]            idx_q, idx_d;
	logic [1:0]               bit_q, bit_d;
	logic [VALUE_WIDTH-1:0]   mag_q;
	logic [4*NDEC-1:0]        bcd_q;
	logic [4*NDEC-1:0]        bcd_next;
	logic                     dst_valid_q;
	logic [6:0]               character_q;
	logic                     last_q;

	logic                     accept;
	logic                     cmd_ok;
	logic                     neg_in;
	logic [VALUE_WIDTH-1:0]   mag_in;
	logic                     out_load;
	logic                     out_en;
	logic [6:0]               out_char;
	logic                     out_last;
	logic                     emit_last;
	logic [3:0]               digit;
	logic [6:0]               sel_char;

	assign src_ready = (state_q == ST_IDLE);
	assign accept    = src_valid && src_ready;
	assign cmd_ok    = (command <= RADIX_BCD);
	assign neg_in    = value[VALUE_WIDTH-1];
	assign mag_in    = neg_in ? $unsigned(-value) : $unsigned(value);
	assign out_load  = !dst_valid_q || dst_ready;
	assign emit_last = (idx_q == '0) && ((mode_q != RADIX_BCD) || (bit_q == 2'd0));

	srdf_dabble #(
		.NDEC(NDEC)
	) u_dabble (
		.bcd     (bcd_q),
		.shift_in(mag_q[VALUE_WIDTH-1]),
		.bcd_next(bcd_next)
	);

	srdf_char_sel #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.NDEC       (NDEC)
	) u_char_sel (
		.mode     (mode_q),
		.idx      (idx_q),
		.bit_sel  (bit_q),
		.mag      (mag_q),
		.bcd      (bcd_q),
		.digit    (digit),
		.character(sel_char)
	);

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		bit_d    = bit_q;
		out_en   = 1'b0;
		out_char = sel_char;
		out_last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && cmd_ok) begin
					bit_d = 2'd3;
					case (command)
						RADIX_DEC, RADIX_BCD: begin
							state_d = ST_CONV;
							idx_d   = TOP_BIN;
						end
						RADIX_BIN: begin
							state_d = neg_in ? ST_SIGN : ST_SCAN;
							idx_d   = TOP_BIN;
						end
						RADIX_OCT: begin
							state_d = neg_in ? ST_SIGN : ST_SCAN;
							idx_d   = TOP_OCT;
						end
						default: begin
							state_d = neg_in ? ST_SIGN : ST_SCAN;
							idx_d   = TOP_HEX;
						end
					endcase
				end
			end
			ST_CONV: begin
				if (idx_q == '0) begin
					idx_d   = TOP_DEC;
					state_d = neg_q ? ST_SIGN : ST_SCAN;
				end else begin
					idx_d = idx_q - 1'b1;
				end
			end
			ST_SIGN: begin
				if (out_load) begin
					out_en   = 1'b1;
					out_char = CH_MINUS;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if ((idx_q != '0) && (digit == 4'd0)) begin
					idx_d = idx_q - 1'b1;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_load) begin
					out_en   = 1'b1;
					out_last = emit_last;
					if ((mode_q == RADIX_BCD) && (bit_q != 2'd0)) begin
						bit_d = bit_q - 1'b1;
					end else begin
						bit_d = 2'd3;
						if (idx_q == '0) begin
							state_d = ST_IDLE;
						end else begin
							idx_d = idx_q - 1'b1;
						end
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= RADIX_BIN;
			neg_q       <= 1'b0;
			idx_q       <= '0;
			bit_q       <= 2'd3;
			dst_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			bit_q   <= bit_d;
			if (accept && cmd_ok) begin
				mode_q <= radix_t'(command);
				neg_q  <= neg_in;
			end
			if (out_en) begin
				dst_valid_q <= 1'b1;
			end else if (dst_ready) begin
				dst_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && cmd_ok) begin
			mag_q <= mag_in;
			bcd_q <= '0;
		end else if (state_q == ST_CONV) begin
			mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
			bcd_q <= bcd_next;
		end
		if (out_en) begin
			character_q <= out_char;
			last_q      <= out_last;
		end
	end

	assign dst_valid = dst_valid_q;
	assign character = character_q;
	assign last      = last_q;

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(src_valid && src_ready && (command <= RADIX_BCD)) |=> (state_q != ST_IDLE))
		else $error("valid item accepted but sequencer stayed idle");

	a_bit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_EMIT) |-> (bit_q == 2'd3))
		else $error("BCD bit counter not rewound outside emission");

	a_hex_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_EMIT) && (mode_q == RADIX_HEX)) |-> (idx_q <= TOP_HEX))
		else $error("hex digit index beyond top digit");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(dst_valid_q && (character_q == CH_MINUS)) |-> !last_q)
		else $error("sign character flagged as last");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import srdf_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 120;
	localparam int RANDOM_ITEMS = 400;
	localparam logic [2:0] CMD_RSVD5 = 3'd5;
	localparam logic [2:0] CMD_RSVD6 = 3'd6;
	localparam logic [2:0] CMD_RSVD7 = 3'd7;
	localparam logic [127:0] DIGIT_GLYPHS = "0123456789ABCDEF";

	typedef struct {
		logic [31:0] value;
		logic [2:0]  command;
	} job_t;

	typedef struct {
		logic [6:0] character;
		logic       last;
	} glyph_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic src_valid = 1'b0;
	logic src_ready;
	logic signed [31:0] value = '0;
	logic [2:0] command = '0;
	logic dst_valid;
	logic dst_ready = 1'b0;
	logic [6:0] character;
	logic last;

	job_t job_queue[$];
	glyph_t expected_chars[$];
	glyph_t next_glyph;
	int jobs_accepted = 0;
	int jobs_ignored = 0;
	int chars_checked = 0;
	int error_count = 0;
	int cycle_count = 0;
	int radix_hits[5] = '{0, 0, 0, 0, 0};

	signed_radix_digit_formatter #(
		.VALUE_WIDTH(32)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_ready(src_ready),
		.value(value),
		.command(command),
		.dst_valid(dst_valid),
		.dst_ready(dst_ready),
		.character(character),
		.last(last)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what);
		error_count++;
		if (error_count <= 30) begin
			$display("MISMATCH at cycle %0d: %s", cycle_count, what);
		end
	endtask

	// Renders one accepted value into the characters the block must emit.
	function automatic void render_value(input logic [31:0] v, input logic [2:0] cmd);
		logic [31:0] mag;
		int unsigned base;
		logic [3:0] digs[32];
		int count;
		logic [6:0] line[$];
		if (cmd > RADIX_BCD) begin
			jobs_ignored++;
			return;
		end
		radix_hits[cmd]++;
		case (radix_t'(cmd))
			RADIX_BIN: begin
				base = 2;
			end
			RADIX_OCT: begin
				base = 8;
			end
			RADIX_HEX: begin
				base = 16;
			end
			default: begin
				base = 10;
			end
		endcase
		mag = v[31] ? (~v + 32'd1) : v;
		count = 0;
		if (mag == 32'd0) begin
			digs[0] = 4'd0;
			count = 1;
		end else begin
			while (mag != 32'd0) begin
				digs[count] = 4'(mag % base);
				mag = mag / base;
				count++;
			end
		end
		if (v[31]) begin
			line.push_back(CH_MINUS);
		end
		for (int d = count - 1; d >= 0; d--) begin
			if (cmd == RADIX_BCD) begin
				for (int b = 3; b >= 0; b--) begin
					line.push_back(digs[d][b] ? CH_ONE : CH_ZERO);
				end
			end else begin
				line.push_back(DIGIT_GLYPHS[8 * (15 - digs[d]) +: 7]);
			end
		end
		for (int i = 0; i < line.size(); i++) begin
			expected_chars.push_back('{line[i], i == line.size() - 1});
		end
	endfunction

	function automatic logic [31:0] pick_value();
		logic [31:0] v;
		case ($urandom_range(5))
			0, 1: begin
				v = $urandom();
			end
			2: begin
				v = $urandom_range(20);
			end
			3: begin
				v = -$urandom_range(20);
			end
			4: begin
				v = (32'd1 << $urandom_range(31)) - $urandom_range(1);
				if ($urandom_range(1) == 1) begin
					v = -v;
				end
			end
			default: begin
				case ($urandom_range(3))
					0: v = 32'h8000_0000;
					1: v = 32'h8000_0001;
					2: v = 32'h7FFF_FFFF;
					default: v = 32'hFFFF_FFFF;
				endcase
			end
		endcase
		return v;
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d characters still due", cycle_count,
				expected_chars.size());
			$display("[signed_radix_digit_formatter] ERROR");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
			value <= '0;
			command <= '0;
		end else begin
			if (src_valid && src_ready) begin
				render_value(value, command);
				jobs_accepted++;
			end
			if (!src_valid || src_ready) begin
				if (job_queue.size() != 0 && ((jobs_accepted >= 200 && jobs_accepted < 320)
						|| $urandom_range(99) >= 15)) begin
					job_t j;
					j = job_queue.pop_front();
					src_valid <= 1'b1;
					value <= j.value;
					command <= j.command;
				end else begin
					src_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_ready <= 1'b0;
		end else begin
			if (dst_valid && dst_ready) begin
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("character %h arrived with nothing pending",
						character));
				end else begin
					next_glyph = expected_chars.pop_front();
					if (character !== next_glyph.character) begin
						report_mismatch($sformatf("character %h, wanted %h", character,
							next_glyph.character));
					end
					if (last !== next_glyph.last) begin
						report_mismatch($sformatf("last %b, wanted %b on character %h", last,
							next_glyph.last, next_glyph.character));
					end
					chars_checked++;
				end
			end
			dst_ready <= (chars_checked >= 3000 && chars_checked < 5000)
				|| $urandom_range(99) >= 15;
		end
	end

	initial begin
		int counted;
		logic [2:0] cmd;
		for (int c = RADIX_BIN; c <= RADIX_BCD; c++) begin
			job_queue.push_back('{32'd0, 3'(c)});
			job_queue.push_back('{32'h8000_0000, 3'(c)});
			job_queue.push_back('{32'h7FFF_FFFF, 3'(c)});
		end
		job_queue.push_back('{32'hFFFF_FFFF, RADIX_BIN});
		job_queue.push_back('{32'd9, RADIX_BCD});
		job_queue.push_back('{-32'd255, RADIX_HEX});
		job_queue.push_back('{32'd8, RADIX_OCT});
		job_queue.push_back('{32'd1_000_000_000, RADIX_DEC});
		job_queue.push_back('{32'hDEAD_BEEF, CMD_RSVD5});
		job_queue.push_back('{32'd0, CMD_RSVD6});
		job_queue.push_back('{32'hFFFF_FFFF, CMD_RSVD7});
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			if ($urandom_range(99) < 8) begin
				cmd = 3'($urandom_range(CMD_RSVD7, CMD_RSVD5));
			end else begin
				cmd = 3'($urandom_range(RADIX_BCD, RADIX_BIN));
				counted++;
			end
			job_queue.push_back('{pick_value(), cmd});
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (job_queue.size() != 0 || src_valid || expected_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_chars.size() != 0) begin
			report_mismatch($sformatf("%0d characters never arrived", expected_chars.size()));
		end

		$display("Converted %0d items (%0d bin, %0d oct, %0d dec, %0d hex, %0d BCD), %0d ignored.",
			jobs_accepted - jobs_ignored, radix_hits[0], radix_hits[1], radix_hits[2],
			radix_hits[3], radix_hits[4], jobs_ignored);
		$display("Checked %0d characters, %0d mismatches.", chars_checked, error_count);
		if (error_count == 0) begin
			$display("[signed_radix_digit_formatter] OK");
		end else begin
			$display("[signed_radix_digit_formatter] ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/srdf_pkg.sv
rtl/core/srdf_dabble.sv
rtl/core/srdf_char_sel.sv
rtl/core/signed_radix_digit_formatter.sv
test/tb.sv
